// File: rtl/csuv_pkg.sv
package csuv_pkg;

  localparam int FracBits   = 16;
  localparam int AngleSteps = 16;
  localparam int TableLen   = 24;
  localparam int PreShift   = 24;
  // CORDIC datapath width: 32-bit input, 24-bit prescale, growth and sign.
  localparam int CordW      = 60;
  localparam int AngW       = 34;
  // The divider is a chain of cells that each produce one quotient bit.
  localparam int DivSteps   = 32 + FracBits;
  localparam int NumW       = 32 + FracBits;
  localparam int LatW       = (DivSteps > AngleSteps) ? DivSteps : AngleSteps;

  localparam logic [0:0] RegHeight = 1'b0;
  localparam logic [0:0] RegTol    = 1'b1;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AngW-1:0]  ang_t;

  function automatic ang_t turn_entry(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      default: v = 32'h00000051;
    endcase
    return ang_t'({2'b00, v});
  endfunction

  // Everything that travels down the row alongside the arithmetic.
  typedef struct packed {
    logic                       vld;
    logic                       cap;
    logic signed [31:0]         z;
    logic                       neg;
    logic [NumW-1:0]            num;
    logic [30:0]                den;
    logic [NumW:0]              rem;
    logic [NumW-1:0]            quo;
    cord_t                      x;
    cord_t                      y;
    ang_t                       ang;
  } cell_t;

endpackage

// File: rtl/csuv_cell.sv
module csuv_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [5:0]                idx_i,
  input  csuv_pkg::cell_t           in_i,
  output csuv_pkg::cell_t           out_o
);

  csuv_pkg::cell_t c_d, c_q;
  csuv_pkg::cord_t dx, dy;
  logic [csuv_pkg::NumW:0] trial;

  always_comb begin
    c_d = in_i;
    // One CORDIC micro-rotation while steps remain.
    if (idx_i < 6'(csuv_pkg::AngleSteps)) begin
      dx = in_i.y >>> idx_i;
      dy = in_i.x >>> idx_i;
      if (!in_i.y[csuv_pkg::CordW-1]) begin
        c_d.x   = in_i.x + dx;
        c_d.y   = in_i.y - dy;
        c_d.ang = in_i.ang + csuv_pkg::turn_entry(int'(idx_i));
      end else begin
        c_d.x   = in_i.x - dx;
        c_d.y   = in_i.y + dy;
        c_d.ang = in_i.ang - csuv_pkg::turn_entry(int'(idx_i));
      end
    end else begin
      dx = '0;
      dy = '0;
    end
    // One restoring division step, numerator bit taken MSB first.
    trial = '0;
    if (idx_i < 6'(csuv_pkg::DivSteps)) begin
      trial = {in_i.rem[csuv_pkg::NumW-1:0],
               in_i.num[csuv_pkg::NumW-1 - idx_i]};
      if (trial >= {{(csuv_pkg::NumW-30){1'b0}}, in_i.den}) begin
        c_d.rem = trial - {{(csuv_pkg::NumW-30){1'b0}}, in_i.den};
        c_d.quo = {in_i.quo[csuv_pkg::NumW-2:0], 1'b1};
      end else begin
        c_d.rem = trial;
        c_d.quo = {in_i.quo[csuv_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= c_d;
    end
  end

  assign out_o = c_q;

endmodule

// File: rtl/cone_surface_uv_mapper.sv
// Cone surface UV mapper: one hit point in, one (u, v, on_cap) result out, one request
// per clock sustained while the output is not stalled. The point flows down a row of
// csuv_pkg::LatW identical cells: the first AngleSteps cells each do one CORDIC
// micro-rotation for the angle, and every cell one restoring division step for the
// side v (48-bit quotient sets the row length). A stall on a valid output freezes
// the whole row; the input stall follows it. Register 0 is cone_height (0 is stored
// as 1), register 1 is cap_tolerance; write them only while the pipeline is empty.
module cone_surface_uv_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] u_coord_o,
  output logic signed [31:0] v_coord_o,
  output logic               on_cap_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int N = csuv_pkg::LatW;

  logic [30:0] height_q;
  logic [15:0] tol_q;
  logic        en;
  logic        out_vld_q;
  logic [31:0] u_q, v_q;
  logic        cap_q;

  csuv_pkg::cell_t head;
  csuv_pkg::cell_t row [N+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 31'd65536;
      tol_q    <= 16'd7;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csuv_pkg::RegHeight: height_q <= (cfg_data_i[30:0] == '0) ? 31'd1 : cfg_data_i[30:0];
        csuv_pkg::RegTol:    tol_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // The row advances whenever the output slot is empty or being taken.
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // Entry: cap test, quadrant fold and numerator setup.
  logic signed [33:0] dsum;
  logic signed [33:0] dabs;
  csuv_pkg::cord_t    px, py;
  logic [31:0]        zmag;
  always_comb begin
    dsum = 34'(signed'(point_z_i)) * 2 + signed'({3'b0, height_q});
    dabs = dsum[33] ? -dsum : dsum;
    px   = csuv_pkg::cord_t'(point_x_i) <<< csuv_pkg::PreShift;
    py   = csuv_pkg::cord_t'(point_y_i) <<< csuv_pkg::PreShift;
    zmag = point_z_i[31] ? 32'(-point_z_i) : 32'(point_z_i);
    head     = '0;
    head.vld = in_valid_i;
    head.cap = dabs <= signed'({17'b0, tol_q, 1'b0});
    head.z   = point_z_i;
    // -z/h: quotient of |z|<<F, negated when z is positive.
    head.neg = !point_z_i[31] && (point_z_i != 0);
    head.num = {zmag, {csuv_pkg::FracBits{1'b0}}};
    head.den = height_q;
    head.x   = px;
    head.y   = py;
    if (point_x_i[31]) begin
      if (!point_y_i[31]) begin
        head.x   = py;
        head.y   = -px;
        head.ang = csuv_pkg::ang_t'(34'sh40000000);
      end else begin
        head.x   = -py;
        head.y   = px;
        head.ang = -csuv_pkg::ang_t'(34'sh40000000);
      end
    end
  end

  // The origin skips the CORDIC; that fact rides along in org_q, and its inputs are zeroed.
  logic origin;
  assign origin = (point_x_i == 0) && (point_y_i == 0);

  csuv_pkg::cell_t head_r;
  always_comb begin
    head_r = head;
    if (origin) begin
      head_r.x   = '0;
      head_r.y   = '0;
      head_r.ang = '0;
    end
  end
  logic [N-1:0] org_q;
  always_ff @(posedge clk_i) begin
    if (en) org_q <= {org_q[N-2:0], origin};
  end

  assign row[0] = head_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    csuv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (6'(g)),
      .in_i   (row[g]),
      .out_o  (row[g+1])
    );
  end

  // Exit: angle to u, cap v and saturation of the side v.
  csuv_pkg::cell_t tl;
  csuv_pkg::ang_t  rnd;
  logic [31:0]     t32;
  logic [csuv_pkg::NumW:0] sq;
  logic [31:0]     vside, vcap, zm;
  localparam int S = 32 - csuv_pkg::FracBits;
  always_comb begin
    tl  = row[N];
    rnd = org_q[N-1] ? csuv_pkg::ang_t'(1) <<< (S-1)
                     : tl.ang + (csuv_pkg::ang_t'(1) <<< (S-1));
    t32 = 32'(rnd >>> S);
    sq  = tl.neg ? -{1'b0, tl.quo} : {1'b0, tl.quo};
    if (!tl.neg && (tl.quo > csuv_pkg::NumW'(32'h7FFFFFFF)))
      vside = 32'h7FFFFFFF;
    else if (tl.neg && (tl.quo > csuv_pkg::NumW'(33'h80000000)))
      vside = 32'h80000000;
    else
      vside = sq[31:0];
    zm   = tl.z[31] ? 32'(-tl.z) : 32'(tl.z);
    zm   = zm & ((32'd1 << csuv_pkg::FracBits) - 32'd1);
    vcap = tl.z[31] ? -zm : zm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= tl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cap_q <= tl.cap;
      u_q   <= tl.cap ? (32'd1 << csuv_pkg::FracBits) - t32 : t32;
      v_q   <= tl.cap ? vcap : vside;
    end
  end

  assign out_valid_o = out_vld_q;
  assign u_coord_o   = u_q;
  assign v_coord_o   = v_q;
  assign on_cap_o    = cap_q;

endmodule

// File: rtl/csuv_checker.sv
module csuv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [31:0] v_coord_o,
  input logic on_cap_o
);

  a_stall_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("input stalled without cause");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(v_coord_o)))
    else $error("stalled result changed");

  a_cap_v_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && on_cap_o) |->
      (v_coord_o[31:16] == 16'h0000 || v_coord_o[31:16] == 16'hFFFF))
    else $error("cap v outside one unit");

endmodule

bind cone_surface_uv_mapper csuv_checker u_csuv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .v_coord_o   (v_coord_o),
  .on_cap_o    (on_cap_o)
);
